// File: hdl/keyword_lexer_tokenizer_unit_defines.svh
// Assertion macros shared by the lexer modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef KEYWORD_LEXER_TOKENIZER_UNIT_DEFINES_SVH
`define KEYWORD_LEXER_TOKENIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define KLT_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lexer assertion failed");

// Next-cycle implication, checked out of reset.
`define KLT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lexer assertion failed");

`else

`define KLT_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define KLT_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// File: hdl/klt_pkg.sv
`default_nettype none

package klt_pkg;

	// Width of the internal byte position counter.
	localparam int POS_BITS = 16;
	typedef logic [POS_BITS-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	// Depth of the token queue; a power of two.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// Token kinds.
	localparam logic [4:0] KIND_KW0       = 5'd0;
	localparam logic [4:0] KIND_IDENT     = 5'd8;
	localparam logic [4:0] KIND_NUMBER    = 5'd9;
	localparam logic [4:0] KIND_LBRACE    = 5'd10;
	localparam logic [4:0] KIND_RBRACE    = 5'd11;
	localparam logic [4:0] KIND_LPAREN    = 5'd12;
	localparam logic [4:0] KIND_RPAREN    = 5'd13;
	localparam logic [4:0] KIND_SEMI      = 5'd14;
	localparam logic [4:0] KIND_COMMA     = 5'd15;
	localparam logic [4:0] KIND_ASSIGN    = 5'd16;
	localparam logic [4:0] KIND_PLUS      = 5'd17;
	localparam logic [4:0] KIND_MINUS     = 5'd18;
	localparam logic [4:0] KIND_STAR      = 5'd19;
	localparam logic [4:0] KIND_SLASH     = 5'd20;
	localparam logic [4:0] KIND_AMP       = 5'd21;
	localparam logic [4:0] KIND_AT        = 5'd22;
	localparam logic [4:0] KIND_END       = 5'd23;
	localparam logic [4:0] KIND_ERROR     = 5'd24;

	// One result token.
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	// One registered input byte.
	typedef struct packed {
		logic       valid;
		logic [7:0] byte_in;
		logic       end_of_input;
	} byte_item_t;

	// Tokens produced by one input byte, zero to two of them.
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} token_wr_t;

endpackage

`default_nettype wire

// File: hdl/klt_byte_if.sv
`default_nettype none

interface klt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source (output valid, output byte_in, output end_of_input, input ready);
	modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: hdl/klt_token_if.sv
`default_nettype none

interface klt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/klt_scan.sv
`default_nettype none

`include "keyword_lexer_tokenizer_unit_defines.svh"

module klt_scan (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire klt_pkg::byte_item_t item,
	output klt_pkg::token_wr_t       wr
);
	import klt_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_HALTED
	} mode_t;

	// Keyword spellings, padded with zero bytes, and their lengths.
	localparam logic [7:0] KW_TEXT [8][6] = '{
		'{"r", "e", "g", 8'h00, 8'h00, 8'h00},
		'{"f", "u", "n", "c", 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"a", "s", "m", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3};

	mode_t      mode_q, mode_d;
	pos_t       pos_q, pos_d;
	pos_t       begin_q, begin_d;
	logic [7:0] alive_q, alive_d;

	logic [7:0] c;
	logic       is_end;
	pos_t       len;
	pos_t       pos_inc;
	logic [4:0] ident_kind;
	logic       has_flush, has_tail;
	token_t     flush_tok, tail_tok;

	function automatic logic is_letter(logic [7:0] ch);
		return (ch inside {["a":"z"], ["A":"Z"], "_"});
	endfunction

	function automatic logic is_digit(logic [7:0] ch);
		return (ch inside {["0":"9"]});
	endfunction

	function automatic logic is_space(logic [7:0] ch);
		return (ch inside {" ", [8'h09:8'h0D]});
	endfunction

	// Keep the keywords whose character at offset idx equals ch.
	function automatic logic [7:0] narrow(logic [7:0] mask, pos_t idx, logic [7:0] ch);
		logic [7:0] res;
		logic [2:0] sel;
		res = '0;
		sel = (idx < pos_t'(6)) ? idx[2:0] : 3'd0;
		for (int k = 0; k < 8; k++) begin
			res[k] = mask[k] && (idx < pos_t'(KW_LEN[k])) && (KW_TEXT[k][sel] == ch);
		end
		return res;
	endfunction

	assign c       = item.byte_in;
	assign is_end  = item.end_of_input || (c == 8'h00);
	assign len     = pos_q - begin_q;
	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + pos_t'(1);

	// First live keyword whose length matches the identifier, else identifier.
	always_comb begin
		ident_kind = KIND_IDENT;
		for (int i = 7; i >= 0; i--) begin
			if (alive_q[i] && (len == pos_t'(KW_LEN[i]))) begin
				ident_kind = KIND_KW0 + 5'(i);
			end
		end
	end

	// Pending identifier or number token.
	always_comb begin
		flush_tok.token_kind   = (mode_q == MODE_IDENT) ? ident_kind : KIND_NUMBER;
		flush_tok.token_start  = 16'(begin_q);
		flush_tok.token_length = 16'(len);
		flush_tok.last_of_run  = !has_tail;
	end

	// Next state and the tokens this byte produces.
	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		begin_d   = begin_q;
		alive_d   = alive_q;
		has_flush = 1'b0;
		has_tail  = 1'b0;
		tail_tok.token_kind   = KIND_ERROR;
		tail_tok.token_start  = 16'(pos_q);
		tail_tok.token_length = 16'd1;
		tail_tok.last_of_run  = 1'b1;

		if (item.valid) begin
			if (is_end) begin
				has_flush = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
				has_tail  = 1'b1;
				tail_tok.token_kind   = KIND_END;
				tail_tok.token_length = 16'd0;
				mode_d  = MODE_IDLE;
				pos_d   = '0;
				begin_d = '0;
				alive_d = '0;
			end else if (mode_q == MODE_HALTED) begin
				mode_d = MODE_HALTED;
			end else if (mode_q == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
				alive_d = (pos_q == POS_MAX) ? 8'h00 : narrow(alive_q, len, c);
				pos_d   = pos_inc;
			end else if (mode_q == MODE_NUMBER && is_digit(c)) begin
				pos_d = pos_inc;
			end else begin
				has_flush = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
				mode_d    = MODE_IDLE;
				pos_d     = pos_inc;
				if (is_space(c)) begin
					mode_d = MODE_IDLE;
				end else if (is_letter(c)) begin
					mode_d  = MODE_IDENT;
					begin_d = pos_q;
					alive_d = narrow(8'hFF, '0, c);
				end else if (is_digit(c)) begin
					mode_d  = MODE_NUMBER;
					begin_d = pos_q;
				end else begin
					has_tail = 1'b1;
					case (c)
						"{":     tail_tok.token_kind = KIND_LBRACE;
						"}":     tail_tok.token_kind = KIND_RBRACE;
						"(":     tail_tok.token_kind = KIND_LPAREN;
						")":     tail_tok.token_kind = KIND_RPAREN;
						";":     tail_tok.token_kind = KIND_SEMI;
						",":     tail_tok.token_kind = KIND_COMMA;
						"=":     tail_tok.token_kind = KIND_ASSIGN;
						"+":     tail_tok.token_kind = KIND_PLUS;
						"-":     tail_tok.token_kind = KIND_MINUS;
						"*":     tail_tok.token_kind = KIND_STAR;
						"/":     tail_tok.token_kind = KIND_SLASH;
						"&":     tail_tok.token_kind = KIND_AMP;
						"@":     tail_tok.token_kind = KIND_AT;
						default: begin
							tail_tok.token_kind = KIND_ERROR;
							mode_d = MODE_HALTED;
						end
					endcase
				end
			end
		end
	end

	// Pack the tokens in output order.
	always_comb begin
		wr.cnt  = {1'b0, has_flush} + {1'b0, has_tail};
		wr.tok0 = has_flush ? flush_tok : tail_tok;
		wr.tok1 = tail_tok;
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			alive_q <= '0;
		end else begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			alive_q <= alive_d;
		end
	end

	`KLT_ASSERT_IMPLIES(a_two_tok_last, clk, arst_n, wr.cnt == 2'd2,
		!wr.tok0.last_of_run && wr.tok1.last_of_run)
	`KLT_ASSERT_IMPLIES(a_one_tok_last, clk, arst_n, wr.cnt == 2'd1, wr.tok0.last_of_run)
	`KLT_ASSERT_IMPLIES(a_halted_quiet, clk, arst_n,
		mode_q == MODE_HALTED && item.valid && !is_end, wr.cnt == 2'd0)

endmodule

`default_nettype wire

// File: hdl/klt_token_fifo.sv
`default_nettype none

`include "keyword_lexer_tokenizer_unit_defines.svh"

module klt_token_fifo (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire klt_pkg::token_wr_t             wr,
	input  wire                                 pop,
	output klt_pkg::token_t                     head,
	output logic                                not_empty,
	output logic [klt_pkg::FIFO_CNT_BITS-1:0]   count
);
	import klt_pkg::*;

	token_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic [FIFO_PTR_BITS-1:0] wr_ptr1;
	logic                     do_pop;

	assign wr_ptr1   = wr_ptr_q + FIFO_PTR_BITS'(1);
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	// Token storage, up to two writes per cycle.
	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.tok0;
		end
		if (wr.cnt == 2'd2) begin
			mem_q[wr_ptr1] <= wr.tok1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(wr.cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(do_pop);
			count_q  <= count_q + FIFO_CNT_BITS'(wr.cnt) - FIFO_CNT_BITS'(do_pop);
		end
	end

	`KLT_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, 1'b1,
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
	`KLT_ASSERT_IMPLIES(a_room_for_write, clk, arst_n, wr.cnt != 2'd0,
		({1'b0, count_q} + {{(FIFO_CNT_BITS-1){1'b0}}, wr.cnt})
			<= (FIFO_CNT_BITS+1)'(FIFO_DEPTH))
	`KLT_ASSERT_NEXT(a_drain_empty, clk, arst_n,
		count_q == FIFO_CNT_BITS'(1) && pop && wr.cnt == 2'd0, count_q == '0)

endmodule

`default_nettype wire

// File: hdl/keyword_lexer_tokenizer_unit.sv
// An accepted byte is registered and scanned; its tokens enter the queue, whose head feeds the output.
// Throughput: one byte per cycle while the queue has room; the token channel moves one token per
// cycle when ready, so a byte's two tokens (a flushed word plus a symbol or end token) leave in turn.
// A four-entry token queue decouples the sides; input stalls when it cannot take two more tokens.
// Reset (arst_n low, asynchronous) clears scan mode, byte position, keyword mask and the queue.
`default_nettype none

module keyword_lexer_tokenizer_unit (
	input  wire         clk,
	input  wire         arst_n,
	klt_byte_if.sink    text,
	klt_token_if.source tokens
);
	import klt_pkg::*;

	byte_item_t               item_s1;
	token_wr_t                wr;
	token_t                   head;
	logic                     not_empty;
	logic [FIFO_CNT_BITS-1:0] count;
	logic [FIFO_CNT_BITS:0]   fill_after;

	// Accept a byte only when the queue keeps room for its two tokens.
	assign fill_after = {1'b0, count} + {{(FIFO_CNT_BITS-1){1'b0}}, wr.cnt};
	assign text.ready = (fill_after <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH - 2));

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= text.valid && text.ready;
			if (text.valid && text.ready) begin
				item_s1.byte_in      <= text.byte_in;
				item_s1.end_of_input <= text.end_of_input;
			end
		end
	end

	klt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.wr     (wr)
	);

	klt_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.pop       (tokens.ready),
		.head      (head),
		.not_empty (not_empty),
		.count     (count)
	);

	// Output channel driven from the queue head.
	assign tokens.valid        = not_empty;
	assign tokens.token_kind   = head.token_kind;
	assign tokens.token_start  = head.token_start;
	assign tokens.token_length = head.token_length;
	assign tokens.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire
